### sv/rkeq_pkg.sv
// Shared constants and types for the rotary knob event queue.
`default_nettype none

package rkeq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int TIMER_BITS  = 16;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int REG_W       = 16;
	localparam logic [REG_W-1:0] DEBOUNCE_RESET   = REG_W'(50);
	localparam logic [REG_W-1:0] LONG_PRESS_RESET = REG_W'(2000);

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_ROTATE  = 3'd1,
		OP_CLICK   = 3'd2,
		OP_POP     = 3'd3,
		OP_DISCARD = 3'd4
	} op_t;

	// register indexes on the configuration port
	localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [1:0] REG_ORIENT     = 2'd2;

	// pending edge kinds and event codes
	localparam logic [1:0] KIND_LEFT  = 2'd0;
	localparam logic [1:0] KIND_RIGHT = 2'd1;
	localparam logic [1:0] KIND_CLICK = 2'd2;
	localparam logic [1:0] EV_LEFT    = 2'd0;
	localparam logic [1:0] EV_SHORT   = 2'd2;
	localparam logic [1:0] EV_LONG    = 2'd3;

	typedef struct packed {
		logic       push;
		logic [1:0] push_code;
		logic       pop;
	} queue_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [1:0]       head_code;
	} queue_stat_t;

endpackage

`default_nettype wire

### sv/rkeq_queue.sv
// Event FIFO: small register file with write/read pointers and a fill count.
`default_nettype none

module rkeq_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  rkeq_pkg::queue_ctrl_t ctrl,
	output rkeq_pkg::queue_stat_t stat
);
	import rkeq_pkg::*;

	logic [1:0]       store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			store_q[wr_ptr_q] <= ctrl.push_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctrl.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (ctrl.pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign stat.count     = count_q;
	assign stat.head_code = store_q[rd_ptr_q];

endmodule

`default_nettype wire

### sv/rotary_knob_event_queue_core.sv
// Rotary knob event queue: debounce and long-press timers feeding an event FIFO.
// Path from input transaction to result on the master side:
// input register, then result register.
// Throughput: one item per cycle; the input side stalls only while the result
// register holds an untaken result and the input register is full.
// Reset (arst_n low): registers back to defaults, timers idle, queue empty.
`default_nettype none

module rotary_knob_event_queue_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,  // [0] b_level, [1] click_level
	input  wire  [2:0]  s_tuser,  // [2:0] op
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,  // [0] event_valid, [2:1] event_code,
	                              // [6:3] pending_count, [7] knob_activity,
	                              // [8] hold_active
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rkeq_pkg::*;

	// configuration registers
	logic [REG_W-1:0] debounce_q;
	logic [REG_W-1:0] long_press_q;
	logic             orient_q;
	logic             cfg_wr;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
			orient_q     <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_DEBOUNCE:   debounce_q   <= pwdata[REG_W-1:0];
				REG_LONG_PRESS: long_press_q <= pwdata[REG_W-1:0];
				REG_ORIENT:     orient_q     <= pwdata[0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_DEBOUNCE:   prdata = 32'(debounce_q);
			REG_LONG_PRESS: prdata = 32'(long_press_q);
			REG_ORIENT:     prdata = 32'(orient_q);
			default:        prdata = '0;
		endcase
	end

	// input register
	logic       vld_s1;
	logic [2:0] op_s1;
	logic       b_s1;
	logic       click_s1;
	logic       adv;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= s_tuser;
			b_s1     <= s_tdata[0];
			click_s1 <= s_tdata[1];
		end
	end

	// knob state
	logic [1:0]            kind_q, kind_d;
	logic [TIMER_BITS-1:0] settle_q, settle_d;
	logic                  settle_run_q, settle_run_d;
	logic [TIMER_BITS-1:0] hold_q, hold_d;
	logic                  hold_run_q, hold_run_d;
	logic                  drop_q, drop_d;

	queue_ctrl_t qctrl;
	queue_stat_t qstat;

	logic       step;
	logic       offer;
	logic [1:0] offer_code;
	logic       ev_valid;
	logic       activity;
	logic       hold_tick;
	logic [CNT_W-1:0] cnt_next;

	assign step = vld_s1 && adv;

	always_comb begin
		kind_d       = kind_q;
		settle_d     = settle_q;
		settle_run_d = settle_run_q;
		hold_d       = hold_q;
		hold_run_d   = hold_run_q;
		drop_d       = drop_q;
		offer        = 1'b0;
		offer_code   = EV_LEFT;
		ev_valid     = 1'b0;
		activity     = 1'b0;
		hold_tick    = 1'b0;
		qctrl.pop    = 1'b0;
		case (op_s1)
			OP_TICK: begin
				hold_tick = 1'b1;
				if (settle_run_q) begin
					if (settle_q <= TIMER_BITS'(1)) begin
						// debounce expiry: long-press timer skips this tick
						hold_tick    = 1'b0;
						settle_d     = '0;
						settle_run_d = 1'b0;
						if (kind_q == KIND_LEFT || kind_q == KIND_RIGHT) begin
							offer      = 1'b1;
							offer_code = kind_q;
						end else if (click_s1) begin
							if (hold_run_q) begin
								hold_run_d = 1'b0;
								hold_d     = '0;
								offer      = 1'b1;
								offer_code = EV_SHORT;
							end
						end else begin
							hold_d     = TIMER_BITS'(long_press_q);
							hold_run_d = 1'b1;
						end
					end else begin
						settle_d = settle_q - 1'b1;
					end
				end
				if (hold_tick && hold_run_q) begin
					if (hold_q <= TIMER_BITS'(1)) begin
						hold_d     = '0;
						hold_run_d = 1'b0;
						offer      = 1'b1;
						offer_code = EV_LONG;
					end else begin
						hold_d = hold_q - 1'b1;
					end
				end
			end
			OP_ROTATE: begin
				kind_d       = (b_s1 == orient_q) ? KIND_RIGHT : KIND_LEFT;
				settle_d     = TIMER_BITS'(debounce_q);
				settle_run_d = 1'b1;
				activity     = 1'b1;
			end
			OP_CLICK: begin
				kind_d       = KIND_CLICK;
				settle_d     = TIMER_BITS'(debounce_q);
				settle_run_d = 1'b1;
				activity     = 1'b1;
			end
			OP_POP: begin
				if (qstat.count != '0) begin
					ev_valid  = 1'b1;
					qctrl.pop = step;
				end
			end
			OP_DISCARD: drop_d = 1'b1;
			default: ;
		endcase
		// any offered event clears the discard flag, queued or not
		if (offer) begin
			drop_d = 1'b0;
		end
		qctrl.push      = step && offer && !drop_q && (qstat.count < CNT_W'(QUEUE_DEPTH));
		qctrl.push_code = offer_code;
		cnt_next        = qstat.count;
		if (qctrl.push) begin
			cnt_next = qstat.count + 1'b1;
		end else if (qctrl.pop) begin
			cnt_next = qstat.count - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q       <= KIND_LEFT;
			settle_q     <= '0;
			settle_run_q <= 1'b0;
			hold_q       <= '0;
			hold_run_q   <= 1'b0;
			drop_q       <= 1'b0;
		end else if (step) begin
			kind_q       <= kind_d;
			settle_q     <= settle_d;
			settle_run_q <= settle_run_d;
			hold_q       <= hold_d;
			hold_run_q   <= hold_run_d;
			drop_q       <= drop_d;
		end
	end

	rkeq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (qctrl),
		.stat   (qstat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata <= {7'd0, hold_run_d, activity, 4'(cnt_next),
				(ev_valid ? qstat.head_code : EV_LEFT), ev_valid};
		end
	end

endmodule

`default_nettype wire

### sv/rkeq_checker.sv
// Port-level checks for the rotary knob event queue, bound to the top level.
`default_nettype none

module rkeq_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata
);
	import rkeq_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// with the result register empty the input side must take a transaction
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// a result without an event carries code zero and a sane count
	a_result_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == 2'd0 &&
			m_tdata[6:3] <= 4'(QUEUE_DEPTH))
		else $error("bad fields in result without event");

endmodule

bind rotary_knob_event_queue_core rkeq_checker u_rkeq_checker (.*);

`default_nettype wire
